@@ sv/brc_pkg.sv @@
// ----------------------------------------------------------------------------
// brc_pkg: shared types and constants for the byte ring channel
// Request and response words, decoded commands, register map and states.
// ----------------------------------------------------------------------------
package brc_pkg;

  // default ring depths and read cap
  localparam int OUT_DEPTH_DEF = 256;
  localparam int IN_DEPTH_DEF  = 64;
  localparam int MAX_READ_DEF  = 64;

  // command queue between front and back
  localparam int QDEPTH = 2;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_OUT_SIZE = 2'd0;
  localparam logic [1:0] REG_IN_SIZE  = 2'd1;
  localparam logic [1:0] REG_SKIP     = 2'd2;

  localparam logic [8:0] OUT_SIZE_RST = 9'd256;
  localparam logic [6:0] IN_SIZE_RST  = 7'd64;
  localparam logic       SKIP_RST     = 1'b1;

  // request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_TGT_WR  = 2'd0,
    REQ_HOST_RD = 2'd1,
    REQ_HOST_WR = 2'd2,
    REQ_TGT_RD  = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       first_of_packet;
    logic [7:0] length;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [7:0] done_count;
    logic       last_result;
  } rsp_t;

  // decoded command classes
  typedef enum logic [2:0] {
    CMD_PKT_FIRST = 3'd0,
    CMD_PKT_EMPTY = 3'd1,
    CMD_PKT_BYTE  = 3'd2,
    CMD_HOST_RD   = 3'd3,
    CMD_HOST_WR   = 3'd4,
    CMD_TGT_RD    = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic [7:0] length;
  } cmd_t;

  typedef struct packed {
    logic [8:0] out_ring_size;
    logic [6:0] in_ring_size;
    logic       skip_mode;
  } cfg_t;

  typedef struct packed {
    logic out_size_wr;
    logic in_size_wr;
  } cfg_evt_t;

  typedef enum logic [1:0] {
    BK_IDLE    = 2'd0,
    BK_HOST_RD = 2'd1,
    BK_TGT_RD  = 2'd2
  } back_state_t;

endpackage

@@ sv/brc_ram.sv @@
// ----------------------------------------------------------------------------
// brc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module brc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/brc_front.sv @@
// ----------------------------------------------------------------------------
// brc_front: request intake and classification
// Takes one request word, decodes it into a command and hands it to the queue.
// ----------------------------------------------------------------------------
module brc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  brc_pkg::req_t req,
  output logic          push,
  output brc_pkg::cmd_t push_cmd,
  input  logic          q_full
);
  import brc_pkg::*;

  logic fr_valid;
  logic fr_valid_next;
  cmd_t fr_cmd;
  cmd_t dec_cmd;
  logic accept;

  // hold the word while the queue is full
  assign push      = fr_valid && !q_full;
  assign req_stall = fr_valid && q_full;
  assign accept    = req_valid && !req_stall;
  assign push_cmd  = fr_cmd;

  // classify the request
  always_comb begin
    dec_cmd.data   = req.data_byte;
    dec_cmd.length = req.length;
    unique case (req_kind_t'(req.req_type))
      REQ_TGT_WR: begin
        if (!req.first_of_packet) begin
          dec_cmd.kind = CMD_PKT_BYTE;
        end else if (req.length == 8'd0) begin
          dec_cmd.kind = CMD_PKT_EMPTY;
        end else begin
          dec_cmd.kind = CMD_PKT_FIRST;
        end
      end
      REQ_HOST_RD: dec_cmd.kind = CMD_HOST_RD;
      REQ_HOST_WR: dec_cmd.kind = CMD_HOST_WR;
      REQ_TGT_RD:  dec_cmd.kind = CMD_TGT_RD;
      default:     dec_cmd.kind = CMD_HOST_RD;
    endcase
  end

  always_comb begin
    fr_valid_next = fr_valid;
    if (accept) begin
      fr_valid_next = 1'b1;
    end else if (push) begin
      fr_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= fr_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd <= dec_cmd;
    end
  end

endmodule

@@ sv/brc_queue.sv @@
// ----------------------------------------------------------------------------
// brc_queue: short command queue
// Decouples the intake stage from the ring engine.
// ----------------------------------------------------------------------------
module brc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brc_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  output brc_pkg::cmd_t head,
  input  logic          pop
);
  import brc_pkg::*;

  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic [QCW-1:0] count_next;

  assign full  = (count == QCW'(QDEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCW'(1);
    end else if (pop && !push) begin
      count_next = count - QCW'(1);
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + QAW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ sv/brc_back.sv @@
// ----------------------------------------------------------------------------
// brc_back: ring engine
// Owns both rings and the packet state, runs one command at a time and
// drives the response register.
// ----------------------------------------------------------------------------
module brc_back #(
  parameter int OUT_DEPTH = brc_pkg::OUT_DEPTH_DEF,
  parameter int IN_DEPTH  = brc_pkg::IN_DEPTH_DEF,
  parameter int MAX_READ  = brc_pkg::MAX_READ_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  brc_pkg::cmd_t     q_head,
  output logic              q_pop,
  input  brc_pkg::cfg_t     cfg,
  input  brc_pkg::cfg_evt_t cfg_evt,
  output logic              rsp_valid,
  output brc_pkg::rsp_t     rsp,
  input  logic              rsp_stall
);
  import brc_pkg::*;

  localparam int OAW = $clog2(OUT_DEPTH);
  localparam int OSW = $clog2(OUT_DEPTH + 1);
  localparam int IAW = $clog2(IN_DEPTH);
  localparam int ISW = $clog2(IN_DEPTH + 1);
  localparam int RCW = $clog2(MAX_READ + 1);

  back_state_t    state, state_next;
  logic [OAW-1:0] out_wr, out_wr_next, out_rd, out_rd_next;
  logic [IAW-1:0] in_wr, in_wr_next, in_rd, in_rd_next;
  logic           pkt_drop, pkt_drop_next;
  logic [7:0]     pkt_left, pkt_left_next, pkt_total, pkt_total_next;
  logic [RCW-1:0] rd_left, rd_left_next, rd_total, rd_total_next;
  logic           rsp_valid_next;
  rsp_t           rsp_next;

  logic [OSW-1:0] osz, used_out, avail_out, out_wr_p1, out_rd_p1;
  logic [ISW-1:0] isz, used_in, avail_in, in_wr_p1, in_rd_p1;
  logic [OAW-1:0] out_wr_adv, out_rd_adv;
  logic [IAW-1:0] in_wr_adv, in_rd_adv;
  logic [31:0]    n_wide;
  logic [RCW-1:0] n_rd;
  logic           fits;
  logic           eff_drop;
  logic [7:0]     eff_left, eff_total, left_n;
  logic           out_free;

  logic           out_ram_we, out_ram_re, in_ram_we, in_ram_re;
  logic [7:0]     out_rdata, in_rdata;

  // clamp ring sizes to the storage depth
  always_comb begin
    if (cfg.out_ring_size < 9'd2) begin
      osz = OSW'(2);
    end else if (32'(cfg.out_ring_size) > OUT_DEPTH) begin
      osz = OSW'(OUT_DEPTH);
    end else begin
      osz = OSW'(cfg.out_ring_size);
    end
    if (cfg.in_ring_size < 7'd2) begin
      isz = ISW'(2);
    end else if (32'(cfg.in_ring_size) > IN_DEPTH) begin
      isz = ISW'(IN_DEPTH);
    end else begin
      isz = ISW'(cfg.in_ring_size);
    end
  end

  // occupancy and free space
  assign used_out  = OSW'(out_wr) - OSW'(out_rd) + ((out_wr < out_rd) ? osz : '0);
  assign avail_out = osz - OSW'(1) - used_out;
  assign used_in   = ISW'(in_wr) - ISW'(in_rd) + ((in_wr < in_rd) ? isz : '0);
  assign avail_in  = isz - ISW'(1) - used_in;
  assign fits      = cfg.skip_mode && (32'(avail_out) >= 32'(q_head.length));

  // position advance with wrap at the ring size
  assign out_wr_p1  = OSW'(out_wr) + OSW'(1);
  assign out_rd_p1  = OSW'(out_rd) + OSW'(1);
  assign in_wr_p1   = ISW'(in_wr) + ISW'(1);
  assign in_rd_p1   = ISW'(in_rd) + ISW'(1);
  assign out_wr_adv = (out_wr_p1 >= osz) ? '0 : OAW'(out_wr_p1);
  assign out_rd_adv = (out_rd_p1 >= osz) ? '0 : OAW'(out_rd_p1);
  assign in_wr_adv  = (in_wr_p1 >= isz) ? '0 : IAW'(in_wr_p1);
  assign in_rd_adv  = (in_rd_p1 >= isz) ? '0 : IAW'(in_rd_p1);

  // target read count: available, requested, capped
  always_comb begin
    n_wide = 32'(used_in);
    if (n_wide > 32'(q_head.length)) begin
      n_wide = 32'(q_head.length);
    end
    if (n_wide > 32'(MAX_READ)) begin
      n_wide = 32'(MAX_READ);
    end
  end
  assign n_rd = RCW'(n_wide);

  // packet view: a first byte opens a fresh packet
  assign eff_drop  = (q_head.kind == CMD_PKT_FIRST) ? !fits : pkt_drop;
  assign eff_left  = (q_head.kind == CMD_PKT_FIRST) ? q_head.length : pkt_left;
  assign eff_total = (q_head.kind == CMD_PKT_FIRST) ? q_head.length : pkt_total;
  assign left_n    = eff_left - 8'd1;

  assign out_free = !rsp_valid || !rsp_stall;

  // command sequencer
  always_comb begin
    state_next     = state;
    out_wr_next    = out_wr;
    out_rd_next    = out_rd;
    in_wr_next     = in_wr;
    in_rd_next     = in_rd;
    pkt_drop_next  = pkt_drop;
    pkt_left_next  = pkt_left;
    pkt_total_next = pkt_total;
    rd_left_next   = rd_left;
    rd_total_next  = rd_total;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    q_pop          = 1'b0;
    out_ram_we     = 1'b0;
    out_ram_re     = 1'b0;
    in_ram_we      = 1'b0;
    in_ram_re      = 1'b0;

    unique case (state)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop          = 1'b1;
          rsp_valid_next = 1'b1;
          rsp_next       = '{out_byte: 8'd0, byte_valid: 1'b0,
                             done_count: 8'd0, last_result: 1'b1};
          case (q_head.kind) inside
            CMD_PKT_EMPTY: begin
              pkt_left_next  = 8'd0;
              pkt_drop_next  = 1'b0;
              pkt_total_next = 8'd0;
            end
            CMD_PKT_FIRST, CMD_PKT_BYTE: begin
              // stray bytes with no open packet fall through as empty results
              if (q_head.kind == CMD_PKT_FIRST || pkt_left != 8'd0) begin
                if (!eff_drop) begin
                  out_ram_we  = 1'b1;
                  out_wr_next = out_wr_adv;
                end
                pkt_left_next       = left_n;
                rsp_next.byte_valid = !eff_drop;
                if (left_n == 8'd0) begin
                  rsp_next.done_count = eff_drop ? 8'd0 : eff_total;
                  pkt_drop_next       = 1'b0;
                  pkt_total_next      = 8'd0;
                end else begin
                  rsp_next.last_result = 1'b0;
                  pkt_drop_next        = eff_drop;
                  pkt_total_next       = eff_total;
                end
              end
            end
            CMD_HOST_RD: begin
              if (out_rd != out_wr) begin
                rsp_valid_next = 1'b0;
                out_ram_re     = 1'b1;
                out_rd_next    = out_rd_adv;
                state_next     = BK_HOST_RD;
              end
            end
            CMD_HOST_WR: begin
              if (avail_in != '0) begin
                in_ram_we  = 1'b1;
                in_wr_next = in_wr_adv;
                rsp_next   = '{out_byte: 8'd0, byte_valid: 1'b1,
                               done_count: 8'd1, last_result: 1'b1};
              end
            end
            CMD_TGT_RD: begin
              if (n_rd != '0) begin
                rsp_valid_next = 1'b0;
                in_ram_re      = 1'b1;
                in_rd_next     = in_rd_adv;
                rd_left_next   = n_rd;
                rd_total_next  = n_rd;
                state_next     = BK_TGT_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_HOST_RD: begin
        // response register is free: it was empty when the command left
        rsp_valid_next = 1'b1;
        rsp_next       = '{out_byte: out_rdata, byte_valid: 1'b1,
                           done_count: 8'd1, last_result: 1'b1};
        state_next     = BK_IDLE;
      end
      BK_TGT_RD: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          if (rd_left == RCW'(1)) begin
            rsp_next   = '{out_byte: in_rdata, byte_valid: 1'b1,
                           done_count: 8'(rd_total), last_result: 1'b1};
            state_next = BK_IDLE;
          end else begin
            rsp_next     = '{out_byte: in_rdata, byte_valid: 1'b1,
                             done_count: 8'd0, last_result: 1'b0};
            in_ram_re    = 1'b1;
            in_rd_next   = in_rd_adv;
            rd_left_next = rd_left - RCW'(1);
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase

    // size writes empty the ring; an open outbound packet turns into a drop
    if (cfg_evt.out_size_wr) begin
      out_wr_next = '0;
      out_rd_next = '0;
      if (pkt_left != 8'd0) begin
        pkt_drop_next = 1'b1;
      end
    end
    if (cfg_evt.in_size_wr) begin
      in_wr_next = '0;
      in_rd_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_wr    <= '0;
      out_rd    <= '0;
      in_wr     <= '0;
      in_rd     <= '0;
      pkt_drop  <= 1'b0;
      pkt_left  <= 8'd0;
      pkt_total <= 8'd0;
      rd_left   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_wr    <= out_wr_next;
      out_rd    <= out_rd_next;
      in_wr     <= in_wr_next;
      in_rd     <= in_rd_next;
      pkt_drop  <= pkt_drop_next;
      pkt_left  <= pkt_left_next;
      pkt_total <= pkt_total_next;
      rd_left   <= rd_left_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rsp      <= rsp_next;
    rd_total <= rd_total_next;
  end

  brc_ram #(
    .WIDTH (8),
    .DEPTH (OUT_DEPTH)
  ) u_out_ram (
    .clk     (clk),
    .wr_en   (out_ram_we),
    .wr_addr (out_wr),
    .wr_data (q_head.data),
    .rd_en   (out_ram_re),
    .rd_addr (out_rd),
    .rd_data (out_rdata)
  );

  brc_ram #(
    .WIDTH (8),
    .DEPTH (IN_DEPTH)
  ) u_in_ram (
    .clk     (clk),
    .wr_en   (in_ram_we),
    .wr_addr (in_wr),
    .wr_data (q_head.data),
    .rd_en   (in_ram_re),
    .rd_addr (in_rd),
    .rd_data (in_rdata)
  );

endmodule

@@ sv/byte_ring_channel_unit.sv @@
// ----------------------------------------------------------------------------
// byte_ring_channel_unit: outbound and inbound byte rings with packet drop
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+-----------------------
//   request  | req_valid, req_stall, req        | in, one word per item
//   response | rsp_valid, rsp_stall, rsp        | out, one word per result
//   config   | psel penable pwrite paddr pwdata | APB, prdata readback
//
// Writes finish in the idle state; a host read issues the RAM read and returns
// its byte from BK_HOST_RD; a target read returns one byte per cycle while the
// response is not stalled. The engine runs one command at a time; an intake
// register and a two-entry command queue keep accepting while responses stall.
// Reset is synchronous: ring positions and packet state clear at once; the
// ring storage is not cleared (only occupied slots are ever read).
// ----------------------------------------------------------------------------
module byte_ring_channel_unit #(
  parameter int OUT_DEPTH = brc_pkg::OUT_DEPTH_DEF,
  parameter int IN_DEPTH  = brc_pkg::IN_DEPTH_DEF,
  parameter int MAX_READ  = brc_pkg::MAX_READ_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  brc_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output brc_pkg::rsp_t                rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brc_pkg::PADDR_W-1:0] paddr,
  input  logic [brc_pkg::PDATA_W-1:0] pwdata,
  output logic [brc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import brc_pkg::*;

  cfg_t       cfg;
  cfg_evt_t   cfg_evt;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       push;
  cmd_t       push_cmd;
  logic       q_full;
  logic       q_valid;
  cmd_t       q_head;
  logic       q_pop;

  // register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  assign cfg_evt.out_size_wr = cfg_wr && (reg_idx == REG_OUT_SIZE);
  assign cfg_evt.in_size_wr  = cfg_wr && (reg_idx == REG_IN_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.out_ring_size <= OUT_SIZE_RST;
      cfg.in_ring_size  <= IN_SIZE_RST;
      cfg.skip_mode     <= SKIP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_OUT_SIZE: cfg.out_ring_size <= pwdata[8:0];
        REG_IN_SIZE:  cfg.in_ring_size  <= pwdata[6:0];
        REG_SKIP:     cfg.skip_mode     <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (reg_idx)
      REG_OUT_SIZE: prdata = PDATA_W'(cfg.out_ring_size);
      REG_IN_SIZE:  prdata = PDATA_W'(cfg.in_ring_size);
      REG_SKIP:     prdata = PDATA_W'(cfg.skip_mode);
      default:      prdata = '0;
    endcase
  end

  brc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  brc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  brc_back #(
    .OUT_DEPTH (OUT_DEPTH),
    .IN_DEPTH  (IN_DEPTH),
    .MAX_READ  (MAX_READ)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .cfg_evt   (cfg_evt),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_stall (rsp_stall)
  );

  // a nonzero count only closes an item
  a_count_on_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.done_count == 8'd0 || rsp.last_result))
    else $error("done_count set on a non-final result");

  // a result without a byte carries nothing
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.byte_valid) |-> (rsp.out_byte == 8'd0 && rsp.done_count == 8'd0))
    else $error("empty result carries data");

  // no response word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !rsp_valid)
    else $error("response valid right after reset");

  // the engine only pulls a command that is there, into a free response register
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && (!rsp_valid || !rsp_stall)))
    else $error("command popped from empty queue or into a held response");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: byte ring channel unit
// A directed table walks the corner cases of both rings and the packet logic,
// then phases of random traffic run under several register settings. Both
// channels idle in random bursts. Every response word is compared field by
// field against its typed row or a ring predictor kept in step with each word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int          NUM_PHASES    = 6;

  localparam rsp_t RSP_EMPTY    = {8'h00, 1'b0, 8'h00, 1'b1};
  localparam rsp_t RSP_MID_OK   = {8'h00, 1'b1, 8'h00, 1'b0};
  localparam rsp_t RSP_MID_DROP = {8'h00, 1'b0, 8'h00, 1'b0};
  localparam rsp_t RSP_STORED   = {8'h00, 1'b1, 8'h01, 1'b1};

  typedef enum logic [1:0] {
    ROW_TYPED,
    ROW_PREDICTED,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    req_t       word;
    rsp_t       want;
    logic [1:0] reg_idx;
    logic [8:0] reg_val;
  } dir_row_t;

  typedef struct packed {
    logic [8:0] out_size;
    logic [6:0] in_size;
    logic       skip;
    logic       idle;
    logic       hold_rx;
    logic [7:0] words;
  } phase_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  req_t                req = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  rsp_t                rsp;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_ring_channel_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // ring predictor state
  logic [7:0]  out_mem [OUT_DEPTH_DEF];
  logic [7:0]  in_mem  [IN_DEPTH_DEF];
  int unsigned out_wr = 0, out_rd = 0, in_wr = 0, in_rd = 0;
  int unsigned pkt_left = 0, pkt_total = 0;
  logic        pkt_drop = 1'b0;
  logic [8:0]  cur_out_size = OUT_SIZE_RST;
  logic [6:0]  cur_in_size = IN_SIZE_RST;
  logic        cur_skip = SKIP_RST;

  rsp_t        step_words [$];
  rsp_t        rsp_expected [$];

  bit          idle_on = 1'b1;
  int unsigned hold_ticket = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned clamp_depth(input int unsigned raw, input int unsigned depth);
    if (raw < 2) return 2;
    if (raw > depth) return depth;
    return raw;
  endfunction

  function automatic int unsigned ring_fill(input int unsigned wr, input int unsigned rd,
                                            input int unsigned size);
    return (wr >= rd) ? (wr - rd) : (size - rd + wr);
  endfunction

  function automatic rsp_t make_rsp(input logic [7:0] b, input logic v, input logic [7:0] d,
                                    input logic l);
    return {b, v, d, l};
  endfunction

  function automatic dir_row_t typed_row(input req_kind_t k, input logic [7:0] d, input logic f,
                                         input logic [7:0] n, input rsp_t want);
    dir_row_t r;
    r = '0;
    r.kind = ROW_TYPED;
    r.word = {k, d, f, n};
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t predicted_row(input req_kind_t k, input logic [7:0] d,
                                             input logic f, input logic [7:0] n);
    dir_row_t r;
    r = '0;
    r.kind = ROW_PREDICTED;
    r.word = {k, d, f, n};
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [8:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // apply a register write to the predictor
  function automatic void note_reg_write(input logic [1:0] idx, input logic [31:0] val);
    case (idx)
      REG_OUT_SIZE: begin
        cur_out_size = val[8:0];
        out_wr = 0;
        out_rd = 0;
        // an accepted packet in progress loses the rest of its bytes
        if (pkt_left != 0) pkt_drop = 1'b1;
      end
      REG_IN_SIZE: begin
        cur_in_size = val[6:0];
        in_wr = 0;
        in_rd = 0;
      end
      REG_SKIP: begin
        cur_skip = val[0];
      end
      default: ;
    endcase
  endfunction

  // compute the response words of one request word into step_words
  function automatic void predict_rings(input req_t w);
    int unsigned osz, isz, avail, n, k;
    logic        stored;
    logic [7:0]  b;
    step_words.delete();
    osz = clamp_depth(32'(cur_out_size), OUT_DEPTH_DEF);
    isz = clamp_depth(32'(cur_in_size), IN_DEPTH_DEF);
    if (out_wr >= osz) out_wr = 0;
    if (out_rd >= osz) out_rd = 0;
    if (in_wr >= isz) in_wr = 0;
    if (in_rd >= isz) in_rd = 0;

    case (w.req_type)
      REQ_TGT_WR: begin
        if (w.first_of_packet) begin
          // zero length closes any packet and stores nothing
          if (w.length == 8'd0) begin
            pkt_left = 0;
            pkt_drop = 1'b0;
            pkt_total = 0;
            step_words.push_back(RSP_EMPTY);
            return;
          end
          // decide on the first byte: store the whole packet or drop it
          avail = osz - 1 - ring_fill(out_wr, out_rd, osz);
          pkt_total = 32'(w.length);
          pkt_left = 32'(w.length);
          pkt_drop = !(cur_skip && avail >= 32'(w.length));
        end else if (pkt_left == 0) begin
          // stray byte outside a packet
          step_words.push_back(RSP_EMPTY);
          return;
        end
        stored = !pkt_drop;
        if (stored) begin
          out_mem[out_wr] = w.data_byte;
          out_wr = out_wr + 1;
          if (out_wr >= osz) out_wr = 0;
        end
        pkt_left = pkt_left - 1;
        if (pkt_left == 0) begin
          step_words.push_back(make_rsp(8'h00, stored, pkt_drop ? 8'h00 : 8'(pkt_total), 1'b1));
          pkt_drop = 1'b0;
          pkt_total = 0;
        end else begin
          step_words.push_back(make_rsp(8'h00, stored, 8'h00, 1'b0));
        end
      end
      REQ_HOST_RD: begin
        if (out_rd == out_wr) begin
          step_words.push_back(RSP_EMPTY);
        end else begin
          b = out_mem[out_rd];
          out_rd = out_rd + 1;
          if (out_rd >= osz) out_rd = 0;
          step_words.push_back(make_rsp(b, 1'b1, 8'h01, 1'b1));
        end
      end
      REQ_HOST_WR: begin
        avail = isz - 1 - ring_fill(in_wr, in_rd, isz);
        if (avail == 0) begin
          step_words.push_back(RSP_EMPTY);
        end else begin
          in_mem[in_wr] = w.data_byte;
          in_wr = in_wr + 1;
          if (in_wr >= isz) in_wr = 0;
          step_words.push_back(RSP_STORED);
        end
      end
      default: begin
        // target read: up to the requested count, capped
        n = ring_fill(in_wr, in_rd, isz);
        if (n > 32'(w.length)) n = 32'(w.length);
        if (n > MAX_READ_DEF) n = MAX_READ_DEF;
        if (n == 0) begin
          step_words.push_back(RSP_EMPTY);
          return;
        end
        for (k = 0; k < n; k++) begin
          b = in_mem[in_rd];
          in_rd = in_rd + 1;
          if (in_rd >= isz) in_rd = 0;
          if (k + 1 == n) step_words.push_back(make_rsp(b, 1'b1, 8'(n), 1'b1));
          else step_words.push_back(make_rsp(b, 1'b1, 8'h00, 1'b0));
        end
      end
    endcase
  endfunction

  // offer one request word, hold it until accepted, then queue its results
  task automatic issue_word(input req_t w, input bit typed, input rsp_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (req_stall);
    predict_rings(w);
    if (typed) rsp_expected.push_back(want);
    else foreach (step_words[i]) rsp_expected.push_back(step_words[i]);
  endtask

  // stop offering and wait until every expected word is back
  task automatic drain_rings;
    req_valid <= 1'b0;
    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    drain_rings();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    note_reg_write(idx, val);
  endtask

  task automatic random_traffic(input int unsigned budget, input bit pause_midway);
    int unsigned sent, pick, len, burst, k;
    req_t        w;
    sent = 0;
    while (sent < budget) begin
      if (pause_midway && sent >= budget / 2) begin
        drain_rings();
        pause_midway = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // well-formed packet with random bytes
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          w = $bits(req_t)'($urandom);
          w.req_type = REQ_TGT_WR;
          w.first_of_packet = (k == 0);
          if (k == 0) w.length = 8'(len);
          issue_word(w, 1'b0, '0);
        end
        sent += len;
      end else if (pick < 70) begin
        // burst of host reads or host writes
        burst = $urandom_range(1, 8);
        for (k = 0; k < burst; k++) begin
          w = $bits(req_t)'($urandom);
          w.req_type = (pick < 55) ? REQ_HOST_RD : REQ_HOST_WR;
          issue_word(w, 1'b0, '0);
        end
        sent += burst;
      end else if (pick < 85) begin
        w = $bits(req_t)'($urandom);
        w.req_type = REQ_TGT_RD;
        if ($urandom_range(0, 9) < 7) w.length = 8'($urandom_range(0, 12));
        issue_word(w, 1'b0, '0);
        sent += 1;
      end else if (pick < 95) begin
        // broken packet: any length, cut short
        burst = $urandom_range(0, 3);
        for (k = 0; k <= burst; k++) begin
          w = $bits(req_t)'($urandom);
          w.req_type = REQ_TGT_WR;
          w.first_of_packet = (k == 0);
          issue_word(w, 1'b0, '0);
        end
        sent += burst + 1;
      end else begin
        issue_word($bits(req_t)'($urandom), 1'b0, '0);
        sent += 1;
      end
    end
  endtask

  // check each accepted response word, then pick the stall for the next cycle
  always @(posedge clk) begin
    rsp_t want;
    int unsigned stall_left, hold_left, hold_seen;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_expected.size() == 0) begin
        $error("unexpected response word %h", rsp);
        mismatch_count++;
      end else begin
        want = rsp_expected.pop_front();
        if (rsp.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, rsp.out_byte);
          mismatch_count++;
        end
        if (rsp.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %h, got %h", want.byte_valid, rsp.byte_valid);
          mismatch_count++;
        end
        if (rsp.done_count !== want.done_count) begin
          $error("done_count: expected %h, got %h", want.done_count, rsp.done_count);
          mismatch_count++;
        end
        if (rsp.last_result !== want.last_result) begin
          $error("last_result: expected %h, got %h", want.last_result, rsp.last_result);
          mismatch_count++;
        end
      end
    end
    // a new hold ticket starts a long stretch of stall
    if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    phase_t   phases [NUM_PHASES];

    dir_rows = '{
      // empty rings, stray byte, zero-length packet
      typed_row(REQ_HOST_RD, 8'h00, 1'b0, 8'h00, RSP_EMPTY),
      typed_row(REQ_TGT_RD,  8'h00, 1'b0, 8'd5,  RSP_EMPTY),
      typed_row(REQ_TGT_WR,  8'h77, 1'b0, 8'd9,  RSP_EMPTY),
      typed_row(REQ_TGT_WR,  8'h00, 1'b1, 8'd0,  RSP_EMPTY),
      // three-byte packet, two bytes read back from the host side
      typed_row(REQ_TGT_WR,  8'hFF, 1'b1, 8'd3,  RSP_MID_OK),
      typed_row(REQ_TGT_WR,  8'h00, 1'b0, 8'd0,  RSP_MID_OK),
      typed_row(REQ_TGT_WR,  8'hA5, 1'b0, 8'hFF, make_rsp(8'h00, 1'b1, 8'd3, 1'b1)),
      typed_row(REQ_HOST_RD, 8'h00, 1'b0, 8'h00, make_rsp(8'hFF, 1'b1, 8'd1, 1'b1)),
      typed_row(REQ_HOST_RD, 8'h00, 1'b0, 8'h00, make_rsp(8'h00, 1'b1, 8'd1, 1'b1)),
      // two inbound bytes, read with count zero then the largest count
      typed_row(REQ_HOST_WR, 8'hFF, 1'b0, 8'h00, RSP_STORED),
      typed_row(REQ_HOST_WR, 8'h00, 1'b0, 8'h00, RSP_STORED),
      typed_row(REQ_TGT_RD,  8'h00, 1'b0, 8'd0,  RSP_EMPTY),
      predicted_row(REQ_TGT_RD, 8'h00, 1'b0, 8'hFF),
      // a new first byte abandons the open packet
      typed_row(REQ_TGT_WR,  8'h12, 1'b1, 8'hFF, RSP_MID_DROP),
      typed_row(REQ_TGT_WR,  8'h34, 1'b1, 8'd2,  RSP_MID_OK),
      typed_row(REQ_TGT_WR,  8'h56, 1'b0, 8'd0,  make_rsp(8'h00, 1'b1, 8'd2, 1'b1)),
      // size below range saturates to two: one free slot
      reg_row(REG_OUT_SIZE, 9'd0),
      typed_row(REQ_TGT_WR,  8'h81, 1'b1, 8'd2,  RSP_MID_DROP),
      typed_row(REQ_TGT_WR,  8'h82, 1'b0, 8'd0,  RSP_EMPTY),
      typed_row(REQ_TGT_WR,  8'hC3, 1'b1, 8'd1,  make_rsp(8'h00, 1'b1, 8'd1, 1'b1)),
      typed_row(REQ_HOST_RD, 8'h00, 1'b0, 8'h00, make_rsp(8'hC3, 1'b1, 8'd1, 1'b1)),
      // oversize saturates; skip off refuses; inbound ring of one slot fills
      reg_row(REG_OUT_SIZE, 9'h1FF),
      reg_row(REG_IN_SIZE, 9'd2),
      reg_row(REG_SKIP, 9'd0),
      typed_row(REQ_TGT_WR,  8'h11, 1'b1, 8'd1,  RSP_EMPTY),
      typed_row(REQ_HOST_WR, 8'h9C, 1'b0, 8'h00, RSP_STORED),
      typed_row(REQ_HOST_WR, 8'h11, 1'b0, 8'h00, RSP_EMPTY),
      typed_row(REQ_TGT_RD,  8'h00, 1'b0, 8'd64, make_rsp(8'h9C, 1'b1, 8'd1, 1'b1)),
      // size write mid-packet turns it into a drop
      reg_row(REG_SKIP, 9'd1),
      typed_row(REQ_TGT_WR,  8'h01, 1'b1, 8'd3,  RSP_MID_OK),
      reg_row(REG_OUT_SIZE, 9'd256),
      typed_row(REQ_TGT_WR,  8'h02, 1'b0, 8'd0,  RSP_MID_DROP),
      typed_row(REQ_TGT_WR,  8'h03, 1'b0, 8'd0,  RSP_EMPTY),
      // skip change mid-packet leaves the packet alone
      typed_row(REQ_TGT_WR,  8'h04, 1'b1, 8'd2,  RSP_MID_OK),
      reg_row(REG_SKIP, 9'd0),
      typed_row(REQ_TGT_WR,  8'h05, 1'b0, 8'd0,  make_rsp(8'h00, 1'b1, 8'd2, 1'b1)),
      predicted_row(REQ_HOST_RD, 8'h00, 1'b0, 8'h00),
      reg_row(REG_IN_SIZE, 9'd127)
    };

    phases[0] = {9'd256, 7'd64,  1'b1, 1'b1, 1'b0, 8'd15};
    phases[1] = {9'd0,   7'd1,   1'b1, 1'b1, 1'b0, 8'd15};
    phases[2] = {9'd9,   7'd5,   1'b1, 1'b1, 1'b1, 8'd15};
    phases[3] = {9'h1FF, 7'h7F,  1'b0, 1'b1, 1'b0, 8'd12};
    phases[4] = {9'($urandom_range(2, 300)), 7'($urandom_range(2, 70)), 1'b1, 1'b1, 1'b0, 8'd15};
    phases[5] = {9'd256, 7'd64,  1'b1, 1'b0, 1'b0, 8'd18};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG)
        write_reg(dir_rows[i].reg_idx, 32'(dir_rows[i].reg_val));
      else
        issue_word(dir_rows[i].word, dir_rows[i].kind == ROW_TYPED, dir_rows[i].want);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_OUT_SIZE, 32'(phases[p].out_size));
      write_reg(REG_IN_SIZE, 32'(phases[p].in_size));
      write_reg(REG_SKIP, 32'(phases[p].skip));
      idle_on = phases[p].idle;
      if (phases[p].hold_rx) hold_ticket++;
      random_traffic(32'(phases[p].words), p == 0);
    end

    drain_rings();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
